// File: hdl/pcwbl_pkg.sv
// Shared types, codes and constants of the per-client window byte limiter.
package pcwbl_pkg;

    // Field widths of the request and result words.
    localparam int OP_W      = 2;
    localparam int ID_W      = 6;
    localparam int SIZE_W    = 31;
    localparam int TICK_W    = 32;
    localparam int USAGE_W   = 31;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 4;

    // Default number of client slots.
    localparam int DEF_MAX_CLIENTS = 64;

    // Number of words the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 2;

    // Projected usage above this clears the counter and raises the flag.
    localparam logic [USAGE_W:0] USAGE_CEILING = 32'd1048576000;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = '0;
    localparam logic [TICK_W-1:0]  WINDOW_RESET = 32'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BYTES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 4'd1;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_SEND   = 2'd0,
        OP_WINDOW = 2'd1,
        OP_REMOVE = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    // Back-end sequencer states.
    typedef enum logic {
        B_IDLE,
        B_EXEC
    } back_state_t;

    // A classified request word as it travels through the queue.
    typedef struct packed {
        op_t                op;
        logic               present;
        logic               in_range;
        logic [ID_W-1:0]    client_id;
        logic [SIZE_W-1:0]  data_size;
        logic [TICK_W-1:0]  now_ticks;
    } item_t;

endpackage

// File: hdl/pcwbl_in_if.sv
// Request channel: valid/ready handshake carrying one request word.
interface pcwbl_in_if
    import pcwbl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic               client_present;
    logic [ID_W-1:0]    client_id;
    logic [SIZE_W-1:0]  data_size;
    logic [TICK_W-1:0]  now_ticks;

    modport source (output valid, op, client_present, client_id, data_size, now_ticks,
                    input ready);
    modport sink   (input valid, op, client_present, client_id, data_size, now_ticks,
                    output ready);
endinterface

// File: hdl/pcwbl_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
interface pcwbl_out_if
    import pcwbl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               allowed;
    logic               overflow_cleared;
    logic [USAGE_W-1:0] usage_bytes;

    modport source (output valid, allowed, overflow_cleared, usage_bytes, input ready);
    modport sink   (input valid, allowed, overflow_cleared, usage_bytes, output ready);
endinterface

// File: hdl/pcwbl_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying index and data.
interface pcwbl_cfg_if
    import pcwbl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/pcwbl_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module pcwbl_front
    import pcwbl_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
    input  logic          clk,
    input  logic          rst_n,
    pcwbl_in_if.sink      req,
    output logic          q_valid,
    output item_t         q_item,
    input  logic          q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t                q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg, count_next;
    item_t                new_item;
    logic                 push;

    // Classify the incoming word: decode the op and check the slot range.
    always_comb
    begin
        new_item.op        = op_t'(req.op);
        new_item.present   = req.client_present;
        new_item.in_range  = (32'(req.client_id) < MAX_CLIENTS);
        new_item.client_id = req.client_id;
        new_item.data_size = req.data_size;
        new_item.now_ticks = req.now_ticks;
    end

    assign req.ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_item    = q_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    // Queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: hdl/pcwbl_back.sv
// Back end: reads the usage table, applies the limit rules and registers the result word.
module pcwbl_back
    import pcwbl_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    input  logic [LIMIT_W-1:0] limit_bytes,
    input  logic [TICK_W-1:0]  window_ticks,
    pcwbl_out_if.source        rsp
);

    localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

    back_state_t              state_reg, state_next;
    item_t                    item_reg;
    logic [USAGE_W-1:0]       usage_mem [MAX_CLIENTS];
    logic [USAGE_W-1:0]       rd_data_reg;
    logic                     expired_reg;
    logic [MAX_CLIENTS-1:0]   valid_reg;
    logic [TICK_W-1:0]        window_start_reg;
    logic                     out_valid_reg;
    logic                     allowed_reg;
    logic                     flag_reg;
    logic [USAGE_W-1:0]       usage_reg;

    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         idx;
    logic [TICK_W-1:0]        elapsed;
    logic                     out_free;
    logic                     exec_fire;
    logic                     was_valid;
    logic [USAGE_W-1:0]       base;
    logic [USAGE_W:0]         proj;
    logic                     res_allowed;
    logic                     res_flag;
    logic [USAGE_W-1:0]       res_usage;
    logic                     wr_en;
    logic [USAGE_W-1:0]       wr_data;
    logic                     clr_one;
    logic                     clr_all;
    logic                     ws_load;
    logic [TICK_W-1:0]        ws_value;

    assign rd_idx    = IDX_W'(q_item.client_id);
    assign idx       = IDX_W'(item_reg.client_id);
    assign elapsed   = q_item.now_ticks - window_start_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign exec_fire = (state_reg == B_EXEC) && out_free;

    // Sequencer: take a word, then execute it once the result register is free.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Limit rules: base usage, projection and the resulting table update.
    always_comb
    begin
        was_valid   = item_reg.in_range && valid_reg[idx];
        base        = (was_valid && !expired_reg) ? rd_data_reg : '0;
        proj        = {1'b0, base} + {1'b0, item_reg.data_size};
        res_allowed = 1'b0;
        res_flag    = 1'b0;
        res_usage   = '0;
        wr_en       = 1'b0;
        wr_data     = base;
        clr_one     = 1'b0;
        clr_all     = 1'b0;
        ws_load     = 1'b0;
        ws_value    = '0;
        case (item_reg.op)
            OP_SEND:
            begin
                if (item_reg.present && item_reg.in_range)
                begin
                    if (limit_bytes == '0)
                    begin
                        res_allowed = 1'b1;
                        res_usage   = was_valid ? rd_data_reg : '0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (proj > USAGE_CEILING)
                        begin
                            wr_data     = '0;
                            res_allowed = 1'b1;
                            res_flag    = 1'b1;
                        end
                        else if (proj > {1'b0, limit_bytes})
                        begin
                            wr_data     = base;
                        end
                        else
                        begin
                            wr_data     = proj[USAGE_W-1:0];
                            res_allowed = 1'b1;
                        end
                        res_usage = wr_data;
                    end
                end
            end
            OP_WINDOW:
            begin
                if (expired_reg)
                begin
                    clr_all  = 1'b1;
                    ws_load  = 1'b1;
                    ws_value = item_reg.now_ticks;
                end
                else
                begin
                    res_usage = was_valid ? rd_data_reg : '0;
                end
            end
            OP_REMOVE:
            begin
                clr_one = item_reg.in_range;
            end
            OP_RESET:
            begin
                clr_all  = 1'b1;
                ws_load  = 1'b1;
                ws_value = '0;
            end
            default:
            begin
                res_usage = '0;
            end
        endcase
    end

    // Control state: sequencer, slot valid bits, window start and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            valid_reg        <= '0;
            window_start_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                if (clr_all)
                begin
                    valid_reg <= '0;
                end
                else if (clr_one)
                begin
                    valid_reg[idx] <= 1'b0;
                end
                else if (wr_en)
                begin
                    valid_reg[idx] <= 1'b1;
                end
                if (ws_load)
                begin
                    window_start_reg <= ws_value;
                end
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Usage table: registered read when a word is taken, write when it executes.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= usage_mem[rd_idx];
        end
        if (exec_fire && wr_en)
        begin
            usage_mem[idx] <= wr_data;
        end
    end

    // Word being executed, window expiry and result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg    <= q_item;
            expired_reg <= (elapsed > window_ticks);
        end
        if (exec_fire)
        begin
            allowed_reg <= res_allowed;
            flag_reg    <= res_flag;
            usage_reg   <= res_usage;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.allowed          = allowed_reg;
    assign rsp.overflow_cleared = flag_reg;
    assign rsp.usage_bytes      = usage_reg;

endmodule

// File: hdl/per_client_window_byte_limiter.sv
// A request word goes from the queue to the word register and table read, then to the result register once it is free.
// The back end takes a new word only after the last one has executed its table read and write.
// The two-word queue keeps accepting requests while a result waits to be taken, until it is full.
// Reset clears all slot valid bits, sets the window start to zero, the limit to zero and
// the window length to 1000 ticks; the usage table itself is not cleared and needs no pass.
module per_client_window_byte_limiter
    import pcwbl_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
    input  logic          clk,
    input  logic          rst_n,
    pcwbl_cfg_if.sink     cfg,
    pcwbl_in_if.sink      req,
    pcwbl_out_if.source   rsp
);

    logic [LIMIT_W-1:0]   limit_reg;
    logic [TICK_W-1:0]    window_reg;
    logic                 q_valid;
    item_t                q_item;
    logic                 q_pop;

    // Configuration registers; writes to unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_LIMIT_BYTES)
            begin
                limit_reg <= cfg.data[LIMIT_W-1:0];
            end
            else if (cfg.index == CFG_WINDOW_TICKS)
            begin
                window_reg <= cfg.data;
            end
        end
    end

    // Front end with the request queue.
    pcwbl_front #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // Back end with the usage table.
    pcwbl_back #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .limit_bytes  (limit_reg),
        .window_ticks (window_reg),
        .rsp          (rsp)
    );

endmodule

// File: tb/tb_per_client_window_byte_limiter.sv
// Self-checking testbench of the per-client window byte limiter: directed and random requests.
module tb_per_client_window_byte_limiter;
    import pcwbl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   CLK_HALF       = 5;
    localparam int                   RESET_CYCLES   = 8;
    localparam int                   MAX_GAP        = 14;
    localparam int                   DRAIN_PAUSE    = 3;
    localparam int                   SETTLE_CYCLES  = 10;
    localparam int                   WATCHDOG_LIMIT = 3000;
    localparam int                   REPORT_LIMIT   = 10;
    localparam int                   PHASE_ITEMS    = 300;
    localparam int                   HOLD_STRETCH   = 400;
    localparam int                   SLOTS          = DEF_MAX_CLIENTS;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 4'd9;
    localparam logic [TICK_W-1:0]    TICK_MAX       = 32'hFFFF_FFFF;
    localparam logic [SIZE_W-1:0]    SIZE_MAX       = 31'h7FFF_FFFF;

    // One request word and the result word it should give.
    typedef struct packed {
        op_t               op;
        logic              present;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [TICK_W-1:0] now;
    } request_t;

    typedef struct packed {
        logic               allowed;
        logic               flag;
        logic [USAGE_W-1:0] usage;
    } verdict_t;

    logic clk;
    logic rst_n;

    pcwbl_cfg_if cfg_if ();
    pcwbl_in_if  req_if ();
    pcwbl_out_if rsp_if ();

    per_client_window_byte_limiter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the limiter state and its registers.
    logic [USAGE_W-1:0] usage_mem [SLOTS];
    bit                 slot_live [SLOTS];
    logic [TICK_W-1:0]  win_start;
    logic [LIMIT_W-1:0] lim_reg;
    logic [TICK_W-1:0]  win_reg;
    logic [TICK_W-1:0]  tick_now;

    verdict_t verdicts [$];

    // Idling controls shared between the stimulus and the result side.
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int hold_cycles = 0;

    int n_err      = 0;
    int n_words    = 0;
    int n_results  = 0;
    int n_allowed  = 0;
    int n_refused  = 0;
    int n_flags    = 0;
    int n_settings = 0;
    int idle_count = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Window expiry with wrapping tick arithmetic.
    function automatic bit window_over(input logic [TICK_W-1:0] now);
        logic [TICK_W-1:0] elapsed;
        elapsed = now - win_start;
        return elapsed > win_reg;
    endfunction

    // Applies one request word to the shadow state and returns the expected result.
    function automatic verdict_t limiter_predict(input request_t r);
        verdict_t        v;
        logic [USAGE_W:0] proj;
        v = '0;
        case (r.op)
            OP_SEND:
            begin
                if (r.present)
                begin
                    if (lim_reg == '0)
                    begin
                        v.allowed = 1'b1;
                    end
                    else
                    begin
                        if (!slot_live[r.id])
                        begin
                            usage_mem[r.id] = '0;
                            slot_live[r.id] = 1'b1;
                        end
                        if (window_over(r.now))
                            usage_mem[r.id] = '0;
                        proj = {1'b0, usage_mem[r.id]} + {1'b0, r.size};
                        if (proj > USAGE_CEILING)
                        begin
                            usage_mem[r.id] = '0;
                            v.allowed = 1'b1;
                            v.flag = 1'b1;
                        end
                        else if (proj <= {1'b0, lim_reg})
                        begin
                            usage_mem[r.id] = proj[USAGE_W-1:0];
                            v.allowed = 1'b1;
                        end
                    end
                end
            end
            OP_WINDOW:
            begin
                if (window_over(r.now))
                begin
                    slot_live = '{default: 1'b0};
                    win_start = r.now;
                end
            end
            OP_REMOVE:
            begin
                slot_live[r.id] = 1'b0;
            end
            default:
            begin
                slot_live = '{default: 1'b0};
                win_start = '0;
            end
        endcase
        // The counter is reported for a live slot, except on a send with no client.
        if (slot_live[r.id] && (r.present || r.op != OP_SEND))
            v.usage = usage_mem[r.id];
        return v;
    endfunction

    // Offers one request word, after a random gap when source idling is enabled, and records its expected result.
    task automatic send_req(input request_t r);
        int       gap;
        verdict_t v;
        gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.op             <= r.op;
        req_if.client_present <= r.present;
        req_if.client_id      <= r.id;
        req_if.data_size      <= r.size;
        req_if.now_ticks      <= r.now;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        v = limiter_predict(r);
        verdicts.push_back(v);
        n_words++;
        if (r.op == OP_SEND)
        begin
            if (v.allowed)
                n_allowed++;
            else
                n_refused++;
        end
        if (v.flag)
            n_flags++;
    endtask

    task automatic send(input op_t op, input logic present, input logic [ID_W-1:0] id,
                        input logic [SIZE_W-1:0] size, input logic [TICK_W-1:0] now);
        request_t r;
        r = '{op: op, present: present, id: id, size: size, now: now};
        send_req(r);
    endtask

    // Waits until every expected result has been taken and the pipeline is quiet.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            CFG_LIMIT_BYTES:  lim_reg = data[LIMIT_W-1:0];
            CFG_WINDOW_TICKS: win_reg = data;
            default:          ;
        endcase
    endtask

    task automatic configure(input logic [TICK_W-1:0] lim_word, input logic [TICK_W-1:0] win,
                             input bit poke_unused);
        wait_drained();
        if (poke_unused)
            write_reg(CFG_UNUSED, TICK_MAX);
        write_reg(CFG_LIMIT_BYTES, lim_word);
        write_reg(CFG_WINDOW_TICKS, win);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    // Random request: mostly well-formed traffic on a few clients, some pure noise.
    function automatic request_t random_request();
        request_t r;
        int       sel;
        int       kind;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            r.op      = op_t'($urandom_range(0, 3));
            r.present = 1'($urandom_range(0, 1));
            r.id      = ID_W'($urandom_range(0, SLOTS - 1));
            r.size    = SIZE_W'($urandom());
            r.now     = $urandom();
            return r;
        end
        sel = $urandom_range(0, 99);
        if (sel < 72)
            r.op = OP_SEND;
        else if (sel < 84)
            r.op = OP_WINDOW;
        else if (sel < 94)
            r.op = OP_REMOVE;
        else
            r.op = OP_RESET;
        r.present = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 3) != 0)
            r.id = ID_W'($urandom_range(0, 7));
        else
            r.id = ID_W'($urandom_range(0, SLOTS - 1));
        kind = $urandom_range(0, 9);
        if (kind == 0)
            r.size = SIZE_W'($urandom());
        else if (kind == 1)
            r.size = SIZE_W'(USAGE_CEILING - $urandom_range(0, 4096));
        else if (kind == 2)
            r.size = '0;
        else if (lim_reg == '0)
            r.size = SIZE_W'($urandom_range(0, 4096));
        else
            r.size = SIZE_W'($urandom_range(0, (int'(lim_reg) / 3) + 1));
        // Time mostly creeps forward within the window, with the odd large jump.
        if ($urandom_range(0, 9) == 0)
            tick_now = tick_now + $urandom();
        else
            tick_now = tick_now + $urandom_range(0, (win_reg / 16) + 2);
        r.now = tick_now;
        return r;
    endfunction

    task automatic run_phase(input logic [TICK_W-1:0] lim_word, input logic [TICK_W-1:0] win,
                             input int hold);
        configure(lim_word, win, 1'b0);
        if (hold > 0)
        begin
            src_idle_en = 1'b0;
            snk_idle_en = 1'b0;
            hold_cycles = hold;
        end
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (hold == 0 && i % 50 == 0)
            begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                snk_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_req(random_request());
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // Out of reset the limit is zero: sends pass untracked, absent clients are refused.
    task automatic test_unlimited_and_absent();
        send(OP_SEND, 1'b1, 6'd0, SIZE_MAX, '0);
        send(OP_SEND, 1'b0, 6'd0, 31'd10, '0);
    endtask

    // Counting up to the limit, refusal, expiry, removal and window roll-over.
    task automatic test_limit_and_window();
        // Bit 31 of the limit word lies outside the register and must be dropped.
        configure(32'h8000_03E8, 32'd100, 1'b1);
        send(OP_SEND, 1'b1, 6'd5, 31'd400, 32'd10);
        send(OP_SEND, 1'b1, 6'd5, 31'd600, 32'd20);
        send(OP_SEND, 1'b1, 6'd5, 31'd1, 32'd30);
        send(OP_WINDOW, 1'b1, 6'd5, 31'd0, 32'd50);
        send(OP_SEND, 1'b1, 6'd5, 31'd2000, 32'd200);
        send(OP_SEND, 1'b1, 6'd5, 31'd0, 32'd201);
        send(OP_REMOVE, 1'b1, 6'd5, 31'd0, 32'd202);
        send(OP_WINDOW, 1'b1, 6'd5, 31'd0, 32'd500);
        send(OP_SEND, 1'b0, 6'd63, 31'd5, 32'd501);
    endtask

    // The usage ceiling, the largest sizes and a time stamp at the top of the range.
    task automatic test_ceiling_and_wrap();
        configure({1'b0, SIZE_MAX}, TICK_MAX, 1'b0);
        send(OP_SEND, 1'b1, 6'd63, USAGE_CEILING[SIZE_W-1:0], '0);
        send(OP_SEND, 1'b1, 6'd63, 31'd1, '0);
        send(OP_SEND, 1'b1, 6'd63, SIZE_MAX, 32'd1);
        send(OP_SEND, 1'b1, 6'd62, 31'd0, TICK_MAX);
        send(OP_RESET, 1'b0, 6'd62, SIZE_MAX, TICK_MAX);
    endtask

    // A zero-length window expires on any elapsed tick, including across the wrap.
    task automatic test_zero_window();
        configure(32'd1, '0, 1'b0);
        send(OP_SEND, 1'b1, 6'd1, 31'd1, '0);
        send(OP_SEND, 1'b1, 6'd1, 31'd1, '0);
        send(OP_SEND, 1'b1, 6'd1, 31'd1, 32'd1);
        send(OP_WINDOW, 1'b0, 6'd1, 31'd0, TICK_MAX);
        send(OP_SEND, 1'b1, 6'd1, 31'd1, '0);
        send(OP_WINDOW, 1'b0, 6'd1, 31'd0, 32'd1);
        send(OP_REMOVE, 1'b0, 6'd1, 31'd0, 32'd1);
    endtask

    task automatic test_random_traffic();
        run_phase('0, 32'd1000, 0);
        run_phase(32'd1, '0, 0);
        run_phase($urandom_range(1, 5000), $urandom_range(10, 2000), 0);
        run_phase({1'b0, SIZE_MAX}, TICK_MAX, 0);
        run_phase(USAGE_CEILING - $urandom_range(0, 100000), $urandom(), 0);
    endtask

    // The result side holds off for a long stretch so the block fills and stalls.
    task automatic test_backpressure();
        run_phase(32'd3000, 32'd500, HOLD_STRETCH);
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n                 = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        req_if.valid          = 1'b0;
        req_if.op             = '0;
        req_if.client_present = 1'b0;
        req_if.client_id      = '0;
        req_if.data_size      = '0;
        req_if.now_ticks      = '0;
        slot_live             = '{default: 1'b0};
        win_start             = '0;
        lim_reg               = LIMIT_RESET;
        win_reg               = WINDOW_RESET;
        tick_now              = $urandom();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_unlimited_and_absent();
        test_limit_and_window();
        test_ceiling_and_wrap();
        test_zero_window();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (verdicts.size() != 0)
            n_err++;
        $display("Covered %0d request words over %0d register settings, %0d results checked.",
                 n_words, n_settings, n_results);
        $display("Sends allowed %0d, refused %0d, counters cleared at the ceiling %0d.",
                 n_allowed, n_refused, n_flags);
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls per word, and the long hold-off when asked.
    initial
    begin
        int stall;
        rsp_if.ready = 1'b0;
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = snk_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            n_results++;
            if (verdicts.size() == 0)
            begin
                n_err++;
                if (n_err <= REPORT_LIMIT)
                    $display("%t: result word with nothing expected: %s %0b flag %0b usage %0d",
                             $realtime, "allowed", rsp_if.allowed,
                             rsp_if.overflow_cleared, rsp_if.usage_bytes);
            end
            else
            begin
                want = verdicts.pop_front();
                if (rsp_if.allowed !== want.allowed || rsp_if.overflow_cleared !== want.flag
                        || rsp_if.usage_bytes !== want.usage)
                begin
                    n_err++;
                    if (n_err <= REPORT_LIMIT)
                        $display({"%t: mismatch: expected allowed %0b flag %0b usage %0d, ",
                                  "got %0b %0b %0d"},
                                 $realtime, want.allowed, want.flag, want.usage,
                                 rsp_if.allowed, rsp_if.overflow_cleared, rsp_if.usage_bytes);
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, verdicts.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
